// ----- hw/rtl/swm_pkg.sv -----
// ----------------------------------------------------------------------------
// swm_pkg
// Shared constants for the sliding window median of block timestamps.
// ----------------------------------------------------------------------------
`default_nettype none

package swm_pkg;

  localparam int WINDOW_DEF = 11;  // timestamps kept in the window
  localparam int TIME_W     = 32;  // timestamp width
  localparam int FILL_OUT_W = 4;   // width of the reported fill level

endpackage

`default_nettype wire

// ----- hw/rtl/sliding_window_median.sv -----
// Flow: each accepted item makes one pass over the sorted store through its single
//   read port, one entry per cycle, skipped when the window is empty; in_stall holds
//   off the next item until the result is loaded into the output register, which
//   waits while out_stall holds the previous result.
// Reset: clears fill level, ring pointer, handshake and sequencer state; the
//   timestamp store is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// sliding_window_median
// Keeps the newest WINDOW block timestamps in a sorted memory, each tagged with
// its ring slot. Each new timestamp is merged in by one streaming pass that
// drops the expiring entry when full and reports the median of the updated window.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_median #(
  parameter int WINDOW = swm_pkg::WINDOW_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [swm_pkg::TIME_W-1:0]    block_time,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [swm_pkg::TIME_W-1:0]    median_time,
  output logic [swm_pkg::FILL_OUT_W-1:0] window_fill
);
  import swm_pkg::*;

  localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int FILL_W = $clog2(WINDOW + 1);

  typedef struct packed {
    logic [TIME_W-1:0] stamp;
    logic [SLOT_W-1:0] slot;
  } entry_t;

  typedef enum logic [1:0] {S_IDLE, S_READ, S_FLUSH} state_t;

  state_t            state;
  logic [FILL_W-1:0] fill;
  logic [SLOT_W-1:0] oldest;
  logic [FILL_W-1:0] rd_idx;
  logic              q_vld;
  logic [FILL_W-1:0] wr_idx;
  entry_t            carry;
  logic [TIME_W-1:0] med;

  entry_t            mem [WINDOW];
  entry_t            mem_q;
  logic              mem_we;
  logic [SLOT_W-1:0] mem_wa;
  entry_t            mem_wd;
  logic [SLOT_W-1:0] rd_addr;

  logic              full;
  logic [FILL_W-1:0] fill_next;
  logic [FILL_W-1:0] half;
  logic              issue;
  logic              drop;
  logic              take;
  logic              q_lower;
  entry_t            lo_ent;
  entry_t            hi_ent;
  logic              out_free;
  logic [TIME_W-1:0] med_fin;
  logic [SLOT_W-1:0] oldest_next;

  assign full      = (fill == FILL_W'(WINDOW));
  assign fill_next = full ? fill : fill + 1'b1;
  assign half      = fill_next >> 1;
  assign issue     = (state == S_READ) && (rd_idx < fill);
  assign rd_addr   = rd_idx[SLOT_W-1:0];

  // drop the entry whose ring slot is being overwritten
  assign drop    = q_vld && full && (mem_q.slot == oldest);
  assign take    = q_vld && !drop;
  assign q_lower = (mem_q.stamp < carry.stamp);
  assign lo_ent  = q_lower ? mem_q : carry;
  assign hi_ent  = q_lower ? carry : mem_q;

  assign out_free    = !out_valid || !out_stall;
  assign med_fin     = (wr_idx == half) ? carry.stamp : med;
  assign oldest_next = (oldest == SLOT_W'(WINDOW - 1)) ? '0 : oldest + 1'b1;

  // write index never passes the read index, so in-place merging is safe
  assign mem_we = take || ((state == S_FLUSH) && out_free);
  assign mem_wa = wr_idx[SLOT_W-1:0];
  assign mem_wd = (state == S_FLUSH) ? carry : lo_ent;

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    mem_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      oldest    <= '0;
      rd_idx    <= '0;
      wr_idx    <= '0;
      q_vld     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      q_vld <= issue;
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            carry  <= '{stamp: block_time, slot: oldest};
            rd_idx <= '0;
            wr_idx <= '0;
            state  <= (fill == '0) ? S_FLUSH : S_READ;
          end
        end
        S_READ: begin
          if (issue) begin
            rd_idx <= rd_idx + 1'b1;
          end
          // emit the smaller, carry the larger
          if (take) begin
            carry  <= hi_ent;
            wr_idx <= wr_idx + 1'b1;
            if (wr_idx == half) begin
              med <= lo_ent.stamp;
            end
          end
          if (!issue && q_vld) begin
            state <= S_FLUSH;
          end
        end
        S_FLUSH: begin
          // hold until the output register is free
          if (out_free) begin
            median_time <= med_fin;
            window_fill <= FILL_OUT_W'(fill_next);
            out_valid   <= 1'b1;
            fill        <= fill_next;
            oldest      <= oldest_next;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_W'(WINDOW))
    else $error("fill level above window size");

  a_slot_bound: assert property (@(posedge clk) disable iff (rst)
    oldest <= SLOT_W'(WINDOW - 1))
    else $error("ring pointer out of range");

  a_wr_behind_rd: assert property (@(posedge clk) disable iff (rst)
    take |-> (wr_idx < rd_idx))
    else $error("merge write overtook read");

  a_flush_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_FLUSH && out_free) |-> (wr_idx == fill_next - 1'b1))
    else $error("merged entry count mismatch");

  a_one_result: assert property (@(posedge clk) disable iff (rst)
    (state == S_FLUSH && out_free) |=> (out_valid && state == S_IDLE))
    else $error("result not presented after merge");
`endif

endmodule

`default_nettype wire

// ----- tb/sv/sliding_window_median_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sliding_window_median_tb
// Streams block timestamps into the median filter under random source gaps and
// sink stalls. A local ring of the newest timestamps predicts each median and
// fill level, and every output word is checked in order against it.
// ----------------------------------------------------------------------------

module sliding_window_median_tb;

  localparam int WINDOW      = swm_pkg::WINDOW_DEF;
  localparam int TIME_W      = swm_pkg::TIME_W;
  localparam int FILL_W      = swm_pkg::FILL_OUT_W;
  localparam int RAND_ITEMS  = 1300;
  localparam int DRAIN_CYC   = 40;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int PRINT_CAP   = 40;

  typedef struct packed {
    logic [TIME_W-1:0] median;
    logic [FILL_W-1:0] fill;
  } median_word_t;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  logic [TIME_W-1:0] block_time;
  logic              out_valid;
  logic              out_stall;
  logic [TIME_W-1:0] median_time;
  logic [FILL_W-1:0] window_fill;

  sliding_window_median #(.WINDOW(WINDOW)) u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .block_time  (block_time),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .median_time (median_time),
    .window_fill (window_fill)
  );

  // predictor state: ring of the newest timestamps
  logic [TIME_W-1:0] ts_ring [WINDOW];
  int unsigned       ts_count;
  int unsigned       ts_slot;

  logic [TIME_W-1:0] pending_times[$];
  median_word_t      median_expect_q[$];
  median_word_t      head_word;

  int          mismatches;
  int          gap_left;
  int          stall_left;
  int unsigned cycle_count;
  logic        calm;

  initial begin
    clk = 1'b0;
  end

  always #10 clk = ~clk;

  task automatic report_mismatch(input string field, input logic [TIME_W-1:0] got,
                                 input logic [TIME_W-1:0] want);
    if (mismatches < PRINT_CAP)
      $display("mismatch at cycle %0d: %s got %h want %h", cycle_count, field, got, want);
    mismatches++;
  endtask

  // Element at sorted index n/2 of the first n ring entries.
  function automatic logic [TIME_W-1:0] ring_median(input int unsigned n);
    logic [TIME_W-1:0] buffer [WINDOW];
    logic [TIME_W-1:0] v;
    int j;
    for (int i = 0; i < WINDOW; i++) buffer[i] = ts_ring[i];
    for (int i = 1; i < n; i++) begin
      v = buffer[i];
      j = i;
      while (j > 0 && buffer[j-1] > v) begin
        buffer[j] = buffer[j-1];
        j--;
      end
      buffer[j] = v;
    end
    return buffer[n/2];
  endfunction

  task automatic track_timestamp(input logic [TIME_W-1:0] t);
    median_word_t w;
    ts_ring[ts_slot] = t;
    ts_slot = (ts_slot + 1 >= WINDOW) ? 0 : ts_slot + 1;
    if (ts_count < WINDOW) ts_count++;
    w.median = ring_median(ts_count);
    w.fill   = ts_count[FILL_W-1:0];
    median_expect_q.push_back(w);
  endtask

  // Mostly short idles, a few long ones, none during a calm stretch.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm) return 0;
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(30, 150);
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count % 2500 == 0) calm <= ($urandom_range(0, 3) == 0);
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("== FAIL ==");
      $finish;
    end
  end

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid   <= 1'b0;
      block_time <= '0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) begin
        track_timestamp(block_time);
        gap_left = pick_gap();
      end
      if (gap_left == 0 && pending_times.size() > 0) begin
        in_valid   <= 1'b1;
        block_time <= pending_times.pop_front();
      end else begin
        in_valid   <= 1'b0;
        block_time <= $urandom();
        if (gap_left > 0) gap_left--;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (median_expect_q.size() == 0) begin
          report_mismatch("unexpected word", median_time, '0);
        end else begin
          head_word = median_expect_q.pop_front();
          if (median_time !== head_word.median)
            report_mismatch("median_time", median_time, head_word.median);
          if (window_fill !== head_word.fill)
            report_mismatch("window_fill", TIME_W'(window_fill), TIME_W'(head_word.fill));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  initial begin
    logic [TIME_W-1:0] base;
    int mode;
    int seg;
    int made;

    rst         = 1'b1;
    in_valid    = 1'b0;
    block_time  = '0;
    out_stall   = 1'b0;
    ts_count    = 0;
    ts_slot     = 0;
    mismatches  = 0;
    gap_left    = 0;
    stall_left  = 0;
    cycle_count = 0;
    calm        = 1'b0;
    for (int i = 0; i < WINDOW; i++) ts_ring[i] = '0;

    // fill the window with extremes and duplicates, then wrap it
    pending_times = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0001,
                      32'hFFFF_FFFE, 32'h0000_0005, 32'h0000_0005, 32'h0000_0005,
                      32'h7FFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555,
                      32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000,
                      32'h0000_0000, 32'h0000_1000, 32'h0000_1001, 32'h0000_1002,
                      32'h0000_1003, 32'h0000_1004, 32'h0000_1005, 32'h0000_1006,
                      32'h0000_1007};

    // random segments; chain-like timestamps dominate
    made = 0;
    base = $urandom();
    while (made < RAND_ITEMS) begin
      mode = $urandom_range(0, 9);
      seg  = $urandom_range(5, 60);
      for (int k = 0; k < seg; k++) begin
        case (mode)
          0, 1:    pending_times.push_back($urandom());
          2:       pending_times.push_back(base + $urandom_range(0, 3));
          3:       pending_times.push_back($urandom_range(0, 1) ? TIME_W'($urandom_range(0, 15))
                                           : 32'hFFFF_FFFF - $urandom_range(0, 15));
          4: begin
            base = base - $urandom_range(0, 900);
            pending_times.push_back(base);
          end
          default: begin
            base = base + $urandom_range(0, 1200);
            pending_times.push_back(base - $urandom_range(0, 7200));
          end
        endcase
      end
      made += seg;
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    @(posedge clk);
    while (pending_times.size() > 0 || in_valid || median_expect_q.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);

    if (mismatches == 0 && median_expect_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
